// File: rtl/ffra_pkg.sv
`default_nettype none

package ffra_pkg;

  // table geometry
  localparam int NUM_REGIONS = 16;
  localparam int IDX_W       = $clog2(NUM_REGIONS);

  // address arithmetic: candidate is one bit wider, candidate plus size two bits wider
  localparam int ADDR_W = 32;
  localparam int CAND_W = ADDR_W + 1;
  localparam int SUM_W  = ADDR_W + 2;

  // request kinds carried on in_tuser
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;          // latch request, start walk at head
    logic step;          // advance one list entry
    logic alloc_commit;  // link new region if it fits
    logic free_commit;   // unlink current region
    logic free_miss;     // free request found nothing
    logic out_load;      // move result into output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_free;     // latched request is a free
    logic cur_zero;    // walk reached end of list
    logic alloc_hit;   // gap found before current region
    logic free_match;  // current region matches free address
  } status_t;

endpackage

`default_nettype wire

// File: rtl/ffra_datapath.sv
`default_nettype none

module ffra_datapath (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire ffra_pkg::cmd_t          cmd,
  output ffra_pkg::status_t            status,
  input  wire                          cfg_wr_en,
  input  wire [ffra_pkg::ADDR_W-1:0]   cfg_wr_data,
  input  wire                          req_action,
  input  wire [ffra_pkg::ADDR_W-1:0]   req_size,
  input  wire [ffra_pkg::ADDR_W-1:0]   req_addr,
  output logic [ffra_pkg::ADDR_W-1:0]  out_start,
  output logic                         out_ok
);
  import ffra_pkg::*;

  localparam logic [SUM_W-1:0] ADDR_SPAN = {2'b01, {ADDR_W{1'b0}}};

  // region table
  logic [IDX_W-1:0]       link_r  [NUM_REGIONS];
  logic [ADDR_W-1:0]      start_r [NUM_REGIONS];
  logic [ADDR_W-1:0]      len_r   [NUM_REGIONS];
  logic [NUM_REGIONS-1:0] in_use_r;

  // walk state
  logic [IDX_W-1:0]  cur_r;
  logic [IDX_W-1:0]  prev_r;
  logic [CAND_W-1:0] cand_r;
  logic [ADDR_W-1:0] size_r;
  logic [ADDR_W-1:0] addr_r;
  logic              is_free_r;
  logic [ADDR_W-1:0] heap_base_r;

  // result staging and output register
  logic [ADDR_W-1:0] res_start_r;
  logic              res_ok_r;
  logic [ADDR_W-1:0] out_start_r;
  logic              out_ok_r;

  logic [SUM_W-1:0]  sum;
  logic [ADDR_W-1:0] cur_start;
  logic [ADDR_W-1:0] cur_len;
  logic [IDX_W-1:0]  cur_link;
  logic              fits;
  logic              slot_found;
  logic [IDX_W-1:0]  slot_idx;

  // current entry read and candidate end
  always_comb begin
    cur_start = start_r[cur_r];
    cur_len   = len_r[cur_r];
    cur_link  = link_r[cur_r];
    sum       = {1'b0, cand_r} + {2'b00, size_r};
  end

  // lowest free table entry, entry 0 is the head
  always_comb begin
    slot_found = 1'b0;
    slot_idx   = '0;
    for (int i = NUM_REGIONS - 1; i >= 1; i--) begin
      if (!in_use_r[i]) begin
        slot_found = 1'b1;
        slot_idx   = IDX_W'(i);
      end
    end
  end

  assign fits = (sum <= ADDR_SPAN) && slot_found;

  always_comb begin
    status.is_free    = is_free_r;
    status.cur_zero   = (cur_r == '0);
    status.alloc_hit  = (sum < {2'b00, cur_start});
    status.free_match = (cur_start == addr_r) && (cur_len != '0);
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= '0;
    end else if (cfg_wr_en) begin
      heap_base_r <= cfg_wr_data;
    end
  end

  // walk pointers and list links
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      prev_r   <= '0;
      in_use_r <= {{(NUM_REGIONS-1){1'b0}}, 1'b1};
      for (int i = 0; i < NUM_REGIONS; i++) begin
        link_r[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        cur_r  <= link_r[0];
        prev_r <= '0;
      end else if (cmd.step) begin
        cur_r  <= cur_link;
        prev_r <= cur_r;
      end
      if (cmd.alloc_commit && fits) begin
        link_r[slot_idx]   <= cur_r;
        link_r[prev_r]     <= slot_idx;
        in_use_r[slot_idx] <= 1'b1;
      end
      if (cmd.free_commit) begin
        link_r[prev_r]  <= cur_link;
        link_r[cur_r]   <= '0;
        in_use_r[cur_r] <= 1'b0;
      end
    end
  end

  // payload: request, candidate, region fields, results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand_r    <= {1'b0, heap_base_r};
      size_r    <= req_size;
      addr_r    <= req_addr;
      is_free_r <= req_action;
    end else if (cmd.step) begin
      cand_r <= {1'b0, cur_start} + {1'b0, cur_len};
    end
    if (cmd.alloc_commit) begin
      res_start_r <= fits ? cand_r[ADDR_W-1:0] : '0;
      res_ok_r    <= fits;
      if (fits) begin
        start_r[slot_idx] <= cand_r[ADDR_W-1:0];
        len_r[slot_idx]   <= size_r;
      end
    end
    if (cmd.free_commit) begin
      len_r[cur_r] <= '0;
      res_start_r  <= '0;
      res_ok_r     <= 1'b1;
    end
    if (cmd.free_miss) begin
      res_start_r <= '0;
      res_ok_r    <= 1'b0;
    end
    if (cmd.out_load) begin
      out_start_r <= res_start_r;
      out_ok_r    <= res_ok_r;
    end
  end

  assign out_start = out_start_r;
  assign out_ok    = out_ok_r;

  // head sentinel is always linked
  a_head_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    in_use_r[0])
    else $error("head entry lost its in-use bit");

  // a step never leaves the end of the list
  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (cur_r != '0))
    else $error("walk stepped past end of list");

  // only a linked region is unlinked
  a_free_linked: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.free_commit |-> (cur_r != '0) && in_use_r[cur_r])
    else $error("free unlinked an entry not in the list");

  // a new region takes an entry that was free
  a_alloc_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.alloc_commit && fits) |=> in_use_r[$past(slot_idx)])
    else $error("allocated entry not marked in use");

endmodule

`default_nettype wire

// File: rtl/ffra_ctrl.sv
`default_nettype none

module ffra_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire                out_tready,
  input  wire ffra_pkg::status_t status,
  output ffra_pkg::cmd_t     cmd
);
  import ffra_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_COMMIT,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_tvalid_r;
  logic   out_tvalid_nxt;
  logic   slot_free;

  assign slot_free = !out_tvalid_r || out_tready;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cmd            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (status.is_free == ACT_FREE) begin
          if (status.cur_zero) begin
            cmd.free_miss = 1'b1;
            state_nxt     = S_FINISH;
          end else if (status.free_match) begin
            cmd.free_commit = 1'b1;
            state_nxt       = S_FINISH;
          end else begin
            cmd.step = 1'b1;
          end
        end else begin
          if (status.cur_zero || status.alloc_hit) begin
            state_nxt = S_COMMIT;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      S_COMMIT: begin
        cmd.alloc_commit = 1'b1;
        state_nxt        = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.out_load   = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  // at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.alloc_commit, cmd.free_commit,
              cmd.free_miss, cmd.out_load}))
    else $error("conflicting datapath commands");

  // an accepted transaction starts a walk
  a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_WALK))
    else $error("accepted transaction did not start a walk");

  // a loaded result is presented
  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid_r)
    else $error("result loaded but not presented");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid_r || out_tready))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: rtl/first_fit_region_allocator_top.sv
// channel   dir  handshake             payload
// in_       in   in_tvalid/in_tready   in_tdata: region_size, free_address; in_tuser: action
// out_      out  out_tvalid/out_tready out_tdata: alloc_start; out_tuser: success
// cfg_      in   cfg_wr_en             cfg_wr_data: heap_base
//
// a free goes from acceptance through the walk to the finish state, an allocation
// through the walk, a commit state and then the finish state; the walk covers 0 to
// NUM_REGIONS-1 list entries, one table entry read per cycle
// rst_n is synchronous active low: empties the table, heap_base reads 0
// a finished result waits in the output register; the next request is taken
// while it waits and stalls only at its own finish until the register frees
`default_nettype none

module first_fit_region_allocator_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // region_size [31:0], free_address [63:32]
  input  wire         in_tuser,   // action [0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // alloc_start [31:0]
  output logic        out_tuser,  // success [0]
  input  wire         cfg_wr_en,
  input  wire  [31:0] cfg_wr_data // heap_base [31:0]
);
  import ffra_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  ffra_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // region table and arithmetic
  ffra_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_action  (in_tuser),
    .req_size    (in_tdata[31:0]),
    .req_addr    (in_tdata[63:32]),
    .out_start   (out_tdata),
    .out_ok      (out_tuser)
  );

endmodule

`default_nettype wire
